// ----- rtl/tdat_pkg.sv -----
package tdat_pkg;

    localparam int DEFAULT_NUM_SLOTS = 16;

    localparam int SECS_W = 17;
    localparam logic [SECS_W-1:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [SECS_W-1:0] SECS_PER_MINUTE = 17'd60;

    typedef enum logic [2:0] {
        OP_CREATE = 3'd0,
        OP_START  = 3'd1,
        OP_STOP   = 3'd2,
        OP_MODIFY = 3'd3,
        OP_DELETE = 3'd4,
        OP_TICK   = 3'd5
    } op_t;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_UNUSED = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_FIRED  = 1'b1;

    typedef struct packed {
        logic [2:0] operation;
        logic [3:0] slot;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic       oneshot;
        logic       has_handler;
    } in_item_t;

    typedef struct packed {
        logic       kind;
        logic [3:0] result_slot;
        logic [1:0] status;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic set_used;
        logic clr_used;
        logic set_run;
        logic clr_run;
        logic wr_time;
        logic wr_hnd;
    } store_cmd_t;

    typedef struct packed {
        logic push;
        logic drop;
        logic rotate;
    } order_cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_FIND,
        S_DEL,
        S_READ,
        S_CHECK,
        S_FLUSH,
        S_RESP
    } state_t;

    function automatic logic [SECS_W-1:0] day_seconds(
        input logic [4:0] h,
        input logic [5:0] m,
        input logic [5:0] s
    );
        logic [SECS_W-1:0] sum;
        begin
            sum = SECS_W'(h) * SECS_PER_HOUR + SECS_W'(m) * SECS_PER_MINUTE + SECS_W'(s);
            return sum;
        end
    endfunction

endpackage

// ----- rtl/tdat_order.sv -----
module tdat_order #(
    parameter int NUM_SLOTS = tdat_pkg::DEFAULT_NUM_SLOTS,
    parameter int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
    parameter int CNT_W = $clog2(NUM_SLOTS + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tdat_pkg::order_cmd_t cmd,
    input  logic [SLOT_W-1:0]    new_slot,
    output logic [SLOT_W-1:0]    head,
    output logic [CNT_W-1:0]     count
);

    logic [SLOT_W-1:0] ord_reg [NUM_SLOTS];
    logic [SLOT_W-1:0] ord_next [NUM_SLOTS];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    always_comb
    begin
        ord_next = ord_reg;
        count_next = count_reg;
        if (cmd.push)
        begin
            ord_next[0] = new_slot;
            for (int k = 1; k < NUM_SLOTS; k++)
            begin
                ord_next[k] = ord_reg[k-1];
            end
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.drop)
        begin
            for (int k = 0; k < NUM_SLOTS - 1; k++)
            begin
                ord_next[k] = ord_reg[k+1];
            end
            count_next = count_reg - CNT_W'(1);
        end
        else if (cmd.rotate)
        begin
            for (int k = 0; k < NUM_SLOTS - 1; k++)
            begin
                if (CNT_W'(k) + CNT_W'(1) < count_reg)
                begin
                    ord_next[k] = ord_reg[k+1];
                end
            end
            for (int k = 0; k < NUM_SLOTS; k++)
            begin
                if (CNT_W'(k) + CNT_W'(1) == count_reg)
                begin
                    ord_next[k] = ord_reg[0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ord_reg <= ord_next;
    end

    assign head = ord_reg[0];
    assign count = count_reg;

endmodule

// ----- rtl/tdat_store.sv -----
module tdat_store #(
    parameter int NUM_SLOTS = tdat_pkg::DEFAULT_NUM_SLOTS,
    parameter int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tdat_pkg::store_cmd_t          cmd,
    input  logic [SLOT_W-1:0]             addr,
    input  logic [tdat_pkg::SECS_W-1:0]   wr_secs,
    input  logic                          wr_stops,
    input  logic                          wr_hnd,
    input  logic [SLOT_W-1:0]             rd_addr,
    output logic                          used_bit,
    output logic [tdat_pkg::SECS_W-1:0]   rd_secs,
    output logic                          rd_stops,
    output logic                          rd_hnd,
    output logic                          rd_run
);

    logic [NUM_SLOTS-1:0] used_reg;
    logic [NUM_SLOTS-1:0] used_next;
    logic [NUM_SLOTS-1:0] run_reg;
    logic [NUM_SLOTS-1:0] run_next;

    logic [tdat_pkg::SECS_W:0]   time_mem [NUM_SLOTS];
    logic                        hnd_mem [NUM_SLOTS];
    logic [tdat_pkg::SECS_W:0]   rd_time_reg;
    logic                        rd_hnd_reg;
    logic                        rd_run_reg;

    always_comb
    begin
        used_next = used_reg;
        run_next = run_reg;
        if (cmd.set_used)
        begin
            used_next[addr] = 1'b1;
        end
        if (cmd.clr_used)
        begin
            used_next[addr] = 1'b0;
        end
        if (cmd.set_run)
        begin
            run_next[addr] = 1'b1;
        end
        if (cmd.clr_run)
        begin
            run_next[addr] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            run_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
            run_reg <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_time)
        begin
            time_mem[addr] <= {wr_stops, wr_secs};
        end
        if (cmd.wr_hnd)
        begin
            hnd_mem[addr] <= wr_hnd;
        end
        rd_time_reg <= time_mem[rd_addr];
        rd_hnd_reg <= hnd_mem[rd_addr];
        rd_run_reg <= run_reg[rd_addr];
    end

    assign used_bit = used_reg[addr];
    assign rd_secs = rd_time_reg[tdat_pkg::SECS_W-1:0];
    assign rd_stops = rd_time_reg[tdat_pkg::SECS_W];
    assign rd_hnd = rd_hnd_reg;
    assign rd_run = rd_run_reg;

endmodule

// ----- rtl/time_of_day_alarm_table_top.sv -----
// Time-of-day alarm table.
// Command channel (cmd_valid/cmd_ready/cmd_data) takes one operation per
// transaction: create, start, stop, modify, delete or tick. Result channel
// (res_valid/res_ready/res_data) returns status and fired transactions;
// last marks the final result of a command. Unknown operations and ticks
// that fire nothing return no result.
// One command is in work at a time; cmd_ready is high only while idle.
// Work from acceptance to the result register:
//   start, stop, modify, and any command on an unused slot: dispatch only
//   create: a search upward from slot 0 for the lowest free slot
//   delete: a pass over the recency list that drops the slot
//   tick: each used slot is read, then checked; the recency list is walked
//   newest first through one registered read of the slot memories.
// A finished result waits in the output register while the next command is
// taken; the sequencer holds only when it must emit a new result into a full
// output register that the receiver stalls.
// Reset empties the table and drops any pending result; no clearing pass.
module time_of_day_alarm_table_top #(
    parameter int NUM_SLOTS = tdat_pkg::DEFAULT_NUM_SLOTS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  tdat_pkg::in_item_t  cmd_data,
    output logic                res_valid,
    input  logic                res_ready,
    output tdat_pkg::out_item_t res_data
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);

    tdat_pkg::state_t    state_reg;
    tdat_pkg::state_t    state_next;
    tdat_pkg::in_item_t  item_reg;
    logic [tdat_pkg::SECS_W-1:0] secs_reg;
    logic [CNT_W-1:0]    step_reg;
    logic [CNT_W-1:0]    step_next;
    logic [CNT_W-1:0]    len_reg;
    logic [CNT_W-1:0]    len_next;
    tdat_pkg::out_item_t resp_reg;
    tdat_pkg::out_item_t resp_next;
    logic                pend_valid_reg;
    logic                pend_valid_next;
    logic [SLOT_W-1:0]   pend_slot_reg;
    logic [SLOT_W-1:0]   pend_slot_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    tdat_pkg::out_item_t out_reg;
    tdat_pkg::out_item_t out_next;

    tdat_pkg::store_cmd_t store_cmd;
    tdat_pkg::order_cmd_t order_cmd;
    logic [SLOT_W-1:0]   store_addr;
    logic [SLOT_W-1:0]   head;
    logic [CNT_W-1:0]    count;
    logic                used_bit;
    logic [tdat_pkg::SECS_W-1:0] rd_secs;
    logic                rd_stops;
    logic                rd_hnd;
    logic                rd_run;
    logic                can_emit;
    logic                fire;
    logic                slot_in_range;

    tdat_order #(
        .NUM_SLOTS (NUM_SLOTS),
        .SLOT_W    (SLOT_W),
        .CNT_W     (CNT_W)
    ) u_order (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (order_cmd),
        .new_slot (SLOT_W'(step_reg)),
        .head     (head),
        .count    (count)
    );

    tdat_store #(
        .NUM_SLOTS (NUM_SLOTS),
        .SLOT_W    (SLOT_W)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (store_cmd),
        .addr     (store_addr),
        .wr_secs  (secs_reg),
        .wr_stops (item_reg.oneshot),
        .wr_hnd   (item_reg.has_handler),
        .rd_addr  (head),
        .used_bit (used_bit),
        .rd_secs  (rd_secs),
        .rd_stops (rd_stops),
        .rd_hnd   (rd_hnd),
        .rd_run   (rd_run)
    );

    assign can_emit = !out_valid_reg || res_ready;
    assign fire = rd_run && rd_hnd && (rd_secs == secs_reg);
    assign slot_in_range = (32'(item_reg.slot) < NUM_SLOTS);
    assign cmd_ready = (state_reg == tdat_pkg::S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        step_next = step_reg;
        len_next = len_reg;
        resp_next = resp_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next = pend_slot_reg;
        out_valid_next = out_valid_reg;
        out_next = out_reg;
        store_cmd = '0;
        order_cmd = '0;
        store_addr = SLOT_W'(item_reg.slot);

        if (res_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            tdat_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = tdat_pkg::S_DISPATCH;
                end
            end
            tdat_pkg::S_DISPATCH:
            begin
                resp_next.kind = tdat_pkg::KIND_STATUS;
                resp_next.result_slot = item_reg.slot;
                resp_next.status = tdat_pkg::ST_OK;
                resp_next.last = 1'b1;
                step_next = '0;
                len_next = count;
                pend_valid_next = 1'b0;
                unique case (item_reg.operation)
                    tdat_pkg::OP_CREATE:
                    begin
                        state_next = tdat_pkg::S_FIND;
                    end
                    tdat_pkg::OP_TICK:
                    begin
                        state_next = (count == '0) ? tdat_pkg::S_IDLE : tdat_pkg::S_READ;
                    end
                    tdat_pkg::OP_START, tdat_pkg::OP_STOP, tdat_pkg::OP_MODIFY,
                    tdat_pkg::OP_DELETE:
                    begin
                        if (!(slot_in_range && used_bit))
                        begin
                            resp_next.status = tdat_pkg::ST_UNUSED;
                            state_next = tdat_pkg::S_RESP;
                        end
                        else
                        begin
                            state_next = tdat_pkg::S_RESP;
                            unique case (item_reg.operation)
                                tdat_pkg::OP_START:  store_cmd.set_run = 1'b1;
                                tdat_pkg::OP_STOP:   store_cmd.clr_run = 1'b1;
                                tdat_pkg::OP_MODIFY: store_cmd.wr_time = 1'b1;
                                default:
                                begin
                                    store_cmd.clr_run = 1'b1;
                                    store_cmd.clr_used = 1'b1;
                                    state_next = tdat_pkg::S_DEL;
                                end
                            endcase
                        end
                    end
                    default:
                    begin
                        state_next = tdat_pkg::S_IDLE;
                    end
                endcase
            end
            tdat_pkg::S_FIND:
            begin
                store_addr = SLOT_W'(step_reg);
                if (step_reg == CNT_W'(NUM_SLOTS))
                begin
                    resp_next.result_slot = '0;
                    resp_next.status = tdat_pkg::ST_FULL;
                    state_next = tdat_pkg::S_RESP;
                end
                else if (!used_bit)
                begin
                    store_cmd.set_used = 1'b1;
                    store_cmd.clr_run = 1'b1;
                    store_cmd.wr_time = 1'b1;
                    store_cmd.wr_hnd = 1'b1;
                    order_cmd.push = 1'b1;
                    resp_next.result_slot = 4'(step_reg);
                    state_next = tdat_pkg::S_RESP;
                end
                else
                begin
                    step_next = step_reg + CNT_W'(1);
                end
            end
            tdat_pkg::S_DEL:
            begin
                if (head == SLOT_W'(item_reg.slot))
                begin
                    order_cmd.drop = 1'b1;
                end
                else
                begin
                    order_cmd.rotate = 1'b1;
                end
                step_next = step_reg + CNT_W'(1);
                if (step_reg == len_reg - CNT_W'(1))
                begin
                    state_next = tdat_pkg::S_RESP;
                end
            end
            tdat_pkg::S_READ:
            begin
                state_next = tdat_pkg::S_CHECK;
            end
            tdat_pkg::S_CHECK:
            begin
                store_addr = head;
                if (!(fire && pend_valid_reg && !can_emit))
                begin
                    if (fire)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_next.kind = tdat_pkg::KIND_FIRED;
                            out_next.result_slot = 4'(pend_slot_reg);
                            out_next.status = tdat_pkg::ST_OK;
                            out_next.last = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_slot_next = head;
                        store_cmd.clr_run = rd_stops;
                    end
                    order_cmd.rotate = 1'b1;
                    step_next = step_reg + CNT_W'(1);
                    if (step_reg == len_reg - CNT_W'(1))
                    begin
                        state_next = tdat_pkg::S_FLUSH;
                    end
                    else
                    begin
                        state_next = tdat_pkg::S_READ;
                    end
                end
            end
            tdat_pkg::S_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = tdat_pkg::S_IDLE;
                end
                else if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    out_next.kind = tdat_pkg::KIND_FIRED;
                    out_next.result_slot = 4'(pend_slot_reg);
                    out_next.status = tdat_pkg::ST_OK;
                    out_next.last = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next = tdat_pkg::S_IDLE;
                end
            end
            tdat_pkg::S_RESP:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    out_next = resp_reg;
                    state_next = tdat_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tdat_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tdat_pkg::S_IDLE;
            step_reg <= '0;
            len_reg <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
            len_reg <= len_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            item_reg <= cmd_data;
            secs_reg <= tdat_pkg::day_seconds(cmd_data.hour, cmd_data.minute, cmd_data.second);
        end
        resp_reg <= resp_next;
        pend_slot_reg <= pend_slot_next;
        out_reg <= out_next;
    end

    assign res_valid = out_valid_reg;
    assign res_data = out_reg;

endmodule

// ----- tb/sv/tb_time_of_day_alarm_table_top.sv -----
`timescale 1ns / 1ps

module tb_time_of_day_alarm_table_top;
    import tdat_pkg::*;

    localparam int NUM_SLOTS = 16;
    localparam int RANDOM_ITEMS = 400;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int REPORT_LIMIT = 10;
    localparam int PHASE_LEN = 40;
    localparam logic [2:0] OP_RESERVED_LO = 3'd6;
    localparam logic [2:0] OP_RESERVED_HI = 3'd7;

    typedef struct {
        in_item_t  cmd;
        int        reps;
        int        typed_n;
        out_item_t typed;
    } script_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_ready;
    in_item_t    cmd_data = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    out_item_t   res_data;

    logic        tab_used [NUM_SLOTS];
    logic        tab_run [NUM_SLOTS];
    logic [16:0] tab_secs [NUM_SLOTS];
    logic        tab_oneshot [NUM_SLOTS];
    logic        tab_handler [NUM_SLOTS];
    logic [3:0]  tab_rank [NUM_SLOTS];
    logic [4:0]  tab_hour [NUM_SLOTS];
    logic [5:0]  tab_minute [NUM_SLOTS];
    logic [5:0]  tab_second [NUM_SLOTS];

    out_item_t   made [NUM_SLOTS];
    int          made_n;
    out_item_t   due_results [$];
    script_row_t script [$];

    int          bad_results = 0;
    int          idle_cycles = 0;
    bit          cmd_busy = 1'b1;
    bit          res_busy = 1'b1;

    time_of_day_alarm_table_top #(
        .NUM_SLOTS(NUM_SLOTS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (res_valid && res_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic void note_result(logic kind, logic [3:0] slot, logic [1:0] status);
        made[made_n] = '{kind, slot, status, 1'b0};
        made_n++;
    endfunction

    function automatic void predict_alarms(in_item_t c);
        logic [16:0] when;
        int          free_idx;
        int          used_count;
        logic [3:0]  gone;
        begin
            made_n = 0;
            when = 17'(c.hour) * SECS_PER_HOUR + 17'(c.minute) * SECS_PER_MINUTE
                   + 17'(c.second);
            case (c.operation)
                OP_CREATE:
                begin
                    free_idx = -1;
                    for (int i = 0; i < NUM_SLOTS; i++)
                    begin
                        if (!tab_used[i] && free_idx < 0)
                        begin
                            free_idx = i;
                        end
                    end
                    if (free_idx < 0)
                    begin
                        note_result(KIND_STATUS, 4'd0, ST_FULL);
                    end
                    else
                    begin
                        for (int j = 0; j < NUM_SLOTS; j++)
                        begin
                            if (tab_used[j])
                            begin
                                tab_rank[j] = tab_rank[j] + 4'd1;
                            end
                        end
                        tab_used[free_idx] = 1'b1;
                        tab_run[free_idx] = 1'b0;
                        tab_secs[free_idx] = when;
                        tab_oneshot[free_idx] = c.oneshot;
                        tab_handler[free_idx] = c.has_handler;
                        tab_rank[free_idx] = 4'd0;
                        tab_hour[free_idx] = c.hour;
                        tab_minute[free_idx] = c.minute;
                        tab_second[free_idx] = c.second;
                        note_result(KIND_STATUS, 4'(free_idx), ST_OK);
                    end
                end
                OP_TICK:
                begin
                    used_count = 0;
                    for (int i = 0; i < NUM_SLOTS; i++)
                    begin
                        if (tab_used[i])
                        begin
                            used_count++;
                        end
                    end
                    for (int r = 0; r < used_count; r++)
                    begin
                        for (int i = 0; i < NUM_SLOTS; i++)
                        begin
                            if (tab_used[i] && tab_rank[i] == 4'(r))
                            begin
                                if (tab_run[i] && tab_handler[i] && tab_secs[i] == when)
                                begin
                                    note_result(KIND_FIRED, 4'(i), ST_OK);
                                    if (tab_oneshot[i])
                                    begin
                                        tab_run[i] = 1'b0;
                                    end
                                end
                                break;
                            end
                        end
                    end
                end
                OP_START, OP_STOP, OP_MODIFY, OP_DELETE:
                begin
                    if (!tab_used[c.slot])
                    begin
                        note_result(KIND_STATUS, c.slot, ST_UNUSED);
                    end
                    else
                    begin
                        case (c.operation)
                            OP_START:
                            begin
                                tab_run[c.slot] = 1'b1;
                            end
                            OP_STOP:
                            begin
                                tab_run[c.slot] = 1'b0;
                            end
                            OP_MODIFY:
                            begin
                                tab_secs[c.slot] = when;
                                tab_oneshot[c.slot] = c.oneshot;
                                tab_hour[c.slot] = c.hour;
                                tab_minute[c.slot] = c.minute;
                                tab_second[c.slot] = c.second;
                            end
                            default:
                            begin
                                gone = tab_rank[c.slot];
                                tab_run[c.slot] = 1'b0;
                                tab_used[c.slot] = 1'b0;
                                for (int i = 0; i < NUM_SLOTS; i++)
                                begin
                                    if (tab_used[i] && tab_rank[i] > gone)
                                    begin
                                        tab_rank[i] = tab_rank[i] - 4'd1;
                                    end
                                end
                            end
                        endcase
                        note_result(KIND_STATUS, c.slot, ST_OK);
                    end
                end
                default:
                begin
                end
            endcase
            if (made_n > 0)
            begin
                made[made_n - 1].last = 1'b1;
            end
        end
    endfunction

    function automatic logic [3:0] target_slot();
        int live [$];
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                if (tab_used[i])
                begin
                    live.push_back(i);
                end
            end
            if (live.size() > 0 && $urandom_range(0, 99) < 85)
            begin
                return 4'(live[$urandom_range(0, live.size() - 1)]);
            end
            return 4'($urandom_range(0, NUM_SLOTS - 1));
        end
    endfunction

    function automatic in_item_t random_cmd();
        in_item_t   c;
        int         p;
        int         style;
        logic [3:0] t;
        begin
            c = in_item_t'($bits(in_item_t)'($urandom));
            p = $urandom_range(0, 99);
            if (p < 14)
            begin
                c.operation = OP_CREATE;
            end
            else if (p < 34)
            begin
                c.operation = OP_START;
            end
            else if (p < 42)
            begin
                c.operation = OP_STOP;
            end
            else if (p < 52)
            begin
                c.operation = OP_MODIFY;
            end
            else if (p < 62)
            begin
                c.operation = OP_DELETE;
            end
            else if (p < 97)
            begin
                c.operation = OP_TICK;
            end
            else
            begin
                c.operation = $urandom_range(0, 1) ? OP_RESERVED_HI : OP_RESERVED_LO;
            end
            if (c.operation != OP_CREATE && c.operation != OP_TICK)
            begin
                c.slot = target_slot();
            end
            style = $urandom_range(0, 99);
            if (c.operation == OP_TICK && style < 35)
            begin
                t = target_slot();
                c.hour = tab_hour[t];
                c.minute = tab_minute[t];
                c.second = tab_second[t];
            end
            else if (style < 80)
            begin
                c.hour = 5'($urandom_range(0, 1));
                c.minute = 6'($urandom_range(0, 1));
                c.second = 6'($urandom_range(0, 1));
            end
            return c;
        end
    endfunction

    function automatic script_row_t mk_row(logic [2:0] op, logic [3:0] slot, logic [4:0] h,
                                           logic [5:0] m, logic [5:0] s, logic one,
                                           logic hnd, int reps, int typed_n,
                                           logic [3:0] rslot, logic [1:0] st);
        script_row_t row;
        begin
            row.cmd = '{op, slot, h, m, s, one, hnd};
            row.reps = reps;
            row.typed_n = typed_n;
            row.typed = '{KIND_STATUS, rslot, st, 1'b1};
            return row;
        end
    endfunction

    task automatic send_cmd(input in_item_t c, input int typed_n, input out_item_t typed);
        int gap;
        begin
            gap = cmd_busy ? $urandom_range(0, 7) : 0;
            if (gap > 0)
            begin
                cmd_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            cmd_valid <= 1'b1;
            cmd_data <= c;
            @(posedge clk);
            while (!cmd_ready) @(posedge clk);
            predict_alarms(c);
            if (typed_n < 0)
            begin
                for (int k = 0; k < made_n; k++)
                begin
                    due_results.push_back(made[k]);
                end
            end
            else if (typed_n > 0)
            begin
                due_results.push_back(typed);
            end
        end
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        begin
            if (due_results.size() == 0)
            begin
                if (bad_results < REPORT_LIMIT)
                begin
                    $display("%0t: unexpected result kind=%0d slot=%0d status=%0d last=%0d",
                             $time, got.kind, got.result_slot, got.status, got.last);
                end
                bad_results++;
            end
            else
            begin
                want = due_results.pop_front();
                if (got !== want)
                begin
                    if (bad_results < REPORT_LIMIT)
                    begin
                        $display({"%0t: wrong result: expected kind=%0d slot=%0d ",
                                  "status=%0d last=%0d, got kind=%0d slot=%0d ",
                                  "status=%0d last=%0d"},
                                 $time, want.kind, want.result_slot, want.status, want.last,
                                 got.kind, got.result_slot, got.status, got.last);
                    end
                    bad_results++;
                end
            end
        end
    endtask

    initial
    begin
        int stall;
        int seen;
        seen = 0;
        @(posedge rst_n);
        forever
        begin
            if (seen % PHASE_LEN == 0)
            begin
                res_busy = 1'($urandom_range(0, 1));
            end
            stall = res_busy ? $urandom_range(0, 7) : 0;
            if (stall > 0)
            begin
                res_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ready <= 1'b1;
            @(posedge clk);
            while (!res_valid) @(posedge clk);
            check_result(res_data);
            seen++;
        end
    end

    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("time_of_day_alarm_table_top: mismatch");
        $finish;
    end

    initial
    begin
        in_item_t c;
        int       sent;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            tab_used[i] = 1'b0;
            tab_run[i] = 1'b0;
            tab_secs[i] = '0;
            tab_oneshot[i] = 1'b0;
            tab_handler[i] = 1'b0;
            tab_rank[i] = '0;
            tab_hour[i] = '0;
            tab_minute[i] = '0;
            tab_second[i] = '0;
        end

        script.push_back(mk_row(OP_START, 4'd3, 5'd0, 6'd0, 6'd0, 1'b0, 1'b0, 1, 1, 4'd3, ST_UNUSED));
        script.push_back(mk_row(OP_TICK, 4'd0, 5'd0, 6'd0, 6'd0, 1'b0, 1'b0, 1, 0, 4'd0, ST_OK));
        script.push_back(mk_row(OP_RESERVED_HI, 4'd0, 5'd0, 6'd0, 6'd0, 1'b0, 1'b0, 1, 0, 4'd0, ST_OK));
        script.push_back(mk_row(OP_CREATE, 4'd0, 5'd0, 6'd0, 6'd0, 1'b0, 1'b1, 1, 1, 4'd0, ST_OK));
        script.push_back(mk_row(OP_CREATE, 4'd15, 5'd31, 6'd63, 6'd63, 1'b1, 1'b1, 1, 1, 4'd1, ST_OK));
        script.push_back(mk_row(OP_CREATE, 4'd0, 5'd0, 6'd0, 6'd0, 1'b1, 1'b1, 1, 1, 4'd2, ST_OK));
        script.push_back(mk_row(OP_CREATE, 4'd0, 5'd0, 6'd0, 6'd0, 1'b0, 1'b0, 1, 1, 4'd3, ST_OK));
        script.push_back(mk_row(OP_START, 4'd0, 5'd0, 6'd0, 6'd0, 1'b0, 1'b0, 1, 1, 4'd0, ST_OK));
        script.push_back(mk_row(OP_START, 4'd1, 5'd0, 6'd0, 6'd0, 1'b0, 1'b0, 1, 1, 4'd1, ST_OK));
        script.push_back(mk_row(OP_START, 4'd2, 5'd0, 6'd0, 6'd0, 1'b0, 1'b0, 1, 1, 4'd2, ST_OK));
        script.push_back(mk_row(OP_START, 4'd3, 5'd0, 6'd0, 6'd0, 1'b0, 1'b0, 1, 1, 4'd3, ST_OK));
        script.push_back(mk_row(OP_TICK, 4'd0, 5'd0, 6'd0, 6'd0, 1'b0, 1'b0, 1, -1, 4'd0, ST_OK));
        script.push_back(mk_row(OP_TICK, 4'd0, 5'd31, 6'd63, 6'd63, 1'b0, 1'b0, 1, -1, 4'd0, ST_OK));
        script.push_back(mk_row(OP_MODIFY, 4'd0, 5'd23, 6'd59, 6'd59, 1'b1, 1'b0, 1, 1, 4'd0, ST_OK));
        script.push_back(mk_row(OP_TICK, 4'd0, 5'd23, 6'd59, 6'd59, 1'b0, 1'b0, 1, -1, 4'd0, ST_OK));
        script.push_back(mk_row(OP_STOP, 4'd2, 5'd0, 6'd0, 6'd0, 1'b0, 1'b0, 1, 1, 4'd2, ST_OK));
        script.push_back(mk_row(OP_DELETE, 4'd1, 5'd0, 6'd0, 6'd0, 1'b0, 1'b0, 1, 1, 4'd1, ST_OK));
        script.push_back(mk_row(OP_MODIFY, 4'd1, 5'd1, 6'd2, 6'd3, 1'b0, 1'b0, 1, 1, 4'd1, ST_UNUSED));
        script.push_back(mk_row(OP_CREATE, 4'd0, 5'd12, 6'd30, 6'd0, 1'b0, 1'b1, 1, 1, 4'd1, ST_OK));
        script.push_back(mk_row(OP_CREATE, 4'd0, 5'd0, 6'd0, 6'd0, 1'b0, 1'b1, 12, -1, 4'd0, ST_OK));
        script.push_back(mk_row(OP_CREATE, 4'd0, 5'd0, 6'd0, 6'd0, 1'b0, 1'b1, 1, 1, 4'd0, ST_FULL));
        script.push_back(mk_row(OP_START, 4'd15, 5'd0, 6'd0, 6'd0, 1'b0, 1'b0, 1, 1, 4'd15, ST_OK));
        script.push_back(mk_row(OP_TICK, 4'd0, 5'd0, 6'd0, 6'd0, 1'b0, 1'b0, 1, -1, 4'd0, ST_OK));
        script.push_back(mk_row(OP_DELETE, 4'd15, 5'd0, 6'd0, 6'd0, 1'b0, 1'b0, 1, 1, 4'd15, ST_OK));
        script.push_back(mk_row(OP_DELETE, 4'd15, 5'd0, 6'd0, 6'd0, 1'b0, 1'b0, 1, 1, 4'd15, ST_UNUSED));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[r])
        begin
            for (int k = 0; k < script[r].reps; k++)
            begin
                send_cmd(script[r].cmd, script[r].typed_n, script[r].typed);
            end
        end

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent % PHASE_LEN == 0)
            begin
                cmd_busy = 1'($urandom_range(0, 1));
            end
            c = random_cmd();
            send_cmd(c, -1, '0);
            if (c.operation <= OP_TICK)
            begin
                sent++;
            end
        end
        cmd_valid <= 1'b0;

        while (due_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (bad_results == 0 && due_results.size() == 0)
        begin
            $display("time_of_day_alarm_table_top: match");
        end
        else
        begin
            $display("time_of_day_alarm_table_top: mismatch");
        end
        $finish;
    end

endmodule
